// ===== rtl/core/rcpa_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpa_pkg
// Shared types, codes and defaults of the reference-counted page allocator.
// ----------------------------------------------------------------------------
package rcpa_pkg;

  localparam int PAGE_COUNT_DEF = 32768;
  localparam int COUNT_BITS_DEF = 8;

  localparam int IDX_W     = 15;  // page index field
  localparam int CNT_OUT_W = 8;   // reported count field
  localparam int STAT_W    = 3;
  localparam int ACT_W     = 3;
  localparam int CFG_W     = 16;  // first_usable_page register
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_SEED  = 3'd0,
    ACT_ALLOC = 3'd1,
    ACT_FREE  = 3'd2,
    ACT_INC   = 3'd3,
    ACT_QUERY = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_OOM    = 3'd1,
    STAT_BADIDX = 3'd2,
    STAT_UNREF  = 3'd3,
    STAT_SAT    = 3'd4,
    STAT_FULL   = 3'd5
  } status_t;

  // Register index of first_usable_page (paddr[2] selects the word).
  localparam logic REG_FIRST_USABLE = 1'b0;

  typedef struct packed {
    logic [IDX_W-1:0]     alloc_page;
    logic [CNT_OUT_W-1:0] ref_count;
    logic [STAT_W-1:0]    status;
  } rcpa_result_t;

endpackage

// ===== rtl/core/rcpa_ram.sv =====
// ----------------------------------------------------------------------------
// rcpa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rcpa_ram
  import rcpa_pkg::*;
#(
  parameter int WIDTH = COUNT_BITS_DEF,
  parameter int DEPTH = PAGE_COUNT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/rcpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcpa_ctrl
// Sequencer around the count table and the free stack: read, update, write.
// ----------------------------------------------------------------------------
module rcpa_ctrl
  import rcpa_pkg::*;
#(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CFG_W-1:0]     first_usable_page,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ACT_W-1:0]     action,
  input  logic [IDX_W-1:0]     page_index,
  input  logic                 out_free,
  output logic                 res_valid,
  output rcpa_result_t         res
);

  localparam int AW   = $clog2(PAGE_COUNT);
  localparam int TOPW = $clog2(PAGE_COUNT + 1);
  localparam int CMPW = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

  state_t              state;
  logic [AW-1:0]       clr_addr;
  logic [TOPW-1:0]     top;
  logic [TOPW-1:0]     top_next;
  logic [TOPW-1:0]     top_m1;
  logic [ACT_W-1:0]    act;
  logic [IDX_W-1:0]    page;
  logic                accept;

  logic                tbl_we, tbl_we_x;
  logic [AW-1:0]       tbl_waddr, tbl_waddr_x;
  logic [COUNT_BITS-1:0] tbl_wdata, tbl_wdata_x;
  logic [COUNT_BITS-1:0] tbl_rdata;
  logic                stk_we;
  logic [IDX_W-1:0]    stk_rdata;

  logic                in_pool, usable, stack_full;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic [COUNT_BITS-1:0] cnt_inc;

  assign in_stall = !((state == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign top_m1   = top - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      top      <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(PAGE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            act   <= action;
            page  <= page_index;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          top   <= top_next;
          state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  assign in_pool    = CMPW'(page) < CMPW'(PAGE_COUNT);
  assign usable     = in_pool && ({1'b0, page} >= first_usable_page);
  assign stack_full = (top == TOPW'(PAGE_COUNT));
  assign cnt_dec    = tbl_rdata - CNT_ONE;
  assign cnt_inc    = tbl_rdata + CNT_ONE;

  // Work out the action from the values read at acceptance.
  always_comb begin
    res         = '0;
    cnt         = '0;
    tbl_we_x    = 1'b0;
    tbl_waddr_x = AW'(page);
    tbl_wdata_x = cnt_dec;
    stk_we      = 1'b0;
    top_next    = top;
    unique case (act)
      ACT_SEED: begin
        if (!usable) begin
          res.status = STAT_BADIDX;
        end else begin
          cnt = tbl_rdata;
          if (stack_full) begin
            res.status = STAT_FULL;
          end else begin
            stk_we   = 1'b1;
            top_next = top + 1'b1;
          end
        end
      end
      ACT_ALLOC: begin
        if (top == '0) begin
          res.status = STAT_OOM;
        end else begin
          top_next       = top_m1;
          tbl_we_x       = 1'b1;
          tbl_waddr_x    = AW'(stk_rdata);
          tbl_wdata_x    = CNT_ONE;
          res.alloc_page = stk_rdata;
          cnt            = CNT_ONE;
        end
      end
      ACT_FREE: begin
        if (!usable) begin
          res.status = STAT_BADIDX;
        end else if (tbl_rdata == '0) begin
          res.status = STAT_UNREF;
        end else begin
          tbl_we_x = 1'b1;
          cnt      = cnt_dec;
          // The last reference returns the page to the stack.
          if (cnt_dec == '0) begin
            if (stack_full) begin
              res.status = STAT_FULL;
            end else begin
              stk_we   = 1'b1;
              top_next = top + 1'b1;
            end
          end
        end
      end
      ACT_INC: begin
        if (!in_pool) begin
          res.status = STAT_BADIDX;
        end else if (tbl_rdata == CNT_MAX) begin
          res.status = STAT_SAT;
          cnt        = tbl_rdata;
        end else begin
          tbl_we_x    = 1'b1;
          tbl_wdata_x = cnt_inc;
          cnt         = cnt_inc;
        end
      end
      ACT_QUERY: begin
        if (!in_pool) begin
          res.status = STAT_BADIDX;
        end else begin
          cnt = tbl_rdata;
        end
      end
      default: begin
      end
    endcase
    res.ref_count = CNT_OUT_W'(cnt);
  end

  assign res_valid = (state == S_EXEC);

  // The clearing sweep owns the table write port until it finishes.
  assign tbl_we    = (state == S_CLEAR) || (res_valid && tbl_we_x);
  assign tbl_waddr = (state == S_CLEAR) ? clr_addr : tbl_waddr_x;
  assign tbl_wdata = (state == S_CLEAR) ? '0 : tbl_wdata_x;

  rcpa_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (PAGE_COUNT)
  ) u_count_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (accept),
    .raddr (AW'(page_index)),
    .rdata (tbl_rdata)
  );

  rcpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (PAGE_COUNT)
  ) u_stack_ram (
    .clk   (clk),
    .we    (res_valid && stk_we),
    .waddr (top[AW-1:0]),
    .wdata (page),
    .re    (accept),
    .raddr (top_m1[AW-1:0]),
    .rdata (stk_rdata)
  );

endmodule

// ===== rtl/core/refcounted_page_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// refcounted_page_allocator_unit
// Page allocator with a LIFO free stack and a per-page reference count table.
// ----------------------------------------------------------------------------
// An item on the input channel (action, page_index) seeds, allocates, frees,
// references or queries a page. Each item produces exactly one result item
// (alloc_page, ref_count, status) on the output channel, in order.
// The acceptance edge reads the count table and the top of the free stack,
// and the following cycle updates both memories and loads the output
// register. The read-then-write of the count table port means a new item is
// not accepted while the previous one is in S_EXEC; its result is registered
// as S_EXEC ends.
// The output register holds a result while out_stall is high; in_stall rises
// as well, so an item is accepted only when the previous result is taken.
// After reset the count table is cleared by a sweep, one entry per cycle,
// during which in_stall is high. The free stack is empty after reset. The
// user writes first_usable_page through the APB-style port only while the
// block is idle; the block does not enforce this. Reset sets it to zero.
// ----------------------------------------------------------------------------
module refcounted_page_allocator_unit
  import rcpa_pkg::*;
#(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready,
  // Input channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ACT_W-1:0]     action,
  input  logic [IDX_W-1:0]     page_index,
  // Output channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_W-1:0]     alloc_page,
  output logic [CNT_OUT_W-1:0] ref_count,
  output logic [STAT_W-1:0]    status
);

  logic [CFG_W-1:0] first_usable_page;
  logic             res_valid;
  rcpa_result_t     res;
  logic             out_free;

  // The register word is picked by paddr[2]; the low bits are byte lanes.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FIRST_USABLE)
                ? APB_DW'(first_usable_page) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_usable_page <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_FIRST_USABLE)) begin
      first_usable_page <= pwdata[CFG_W-1:0];
    end
  end

  // The output register is free when empty or being taken at this edge.
  assign out_free = !out_valid || !out_stall;

  rcpa_ctrl #(
    .PAGE_COUNT (PAGE_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .first_usable_page (first_usable_page),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .action            (action),
    .page_index        (page_index),
    .out_free          (out_free),
    .res_valid         (res_valid),
    .res               (res)
  );

  // A result is only produced when the register was free at acceptance.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      alloc_page <= res.alloc_page;
      ref_count  <= res.ref_count;
      status     <= res.status;
    end
  end

endmodule

// ===== rtl/core/rcpa_checker.sv =====
// ----------------------------------------------------------------------------
// rcpa_checker
// Port-level assertions for the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module rcpa_checker
  import rcpa_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [IDX_W-1:0]     alloc_page,
  input logic [CNT_OUT_W-1:0] ref_count,
  input logic [STAT_W-1:0]    status
);

  // A held result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(alloc_page) &&
    $stable(ref_count) && $stable(status))
    else $error("stalled result changed");

  // Every accepted item is followed by a valid result.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("result missing after accepted item");

  // Items are never accepted back to back.
  a_spacing: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted in back-to-back cycles");

  // Only a successful alloc hands out a nonzero page, with one reference.
  a_alloc_page: assert property (@(posedge clk) disable iff (rst)
    out_valid && (alloc_page != '0) |-> (status == STAT_OK) &&
    (ref_count == CNT_OUT_W'(1)))
    else $error("page handed out without a clean alloc");

  // A rejected page index reports nothing else.
  a_badidx: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_BADIDX) |-> (ref_count == '0) &&
    (alloc_page == '0))
    else $error("bad page index with nonzero fields");

endmodule

bind refcounted_page_allocator_unit rcpa_checker u_rcpa_checker (.*);
